// ===== hw/rtl/crr_pkg.sv =====
// crr_pkg: shared types and constants for the binomial call pricer.
// Used by the config registers, the shared multiplier and the top level.
// No dependencies.
`timescale 1ns / 1ps

package crr_pkg;

  // Default lattice depth limit
  localparam int MAX_STEPS_DEF = 64;

  localparam int WORD_W    = 32;
  localparam int STEPS_W   = 7;
  localparam int CFG_IDX_W = 3;

  // Register reset values
  localparam logic [WORD_W-1:0]  UP_RST    = 32'h4000_0000;  // 1.0 in Q2.30
  localparam logic [WORD_W-1:0]  DOWN_RST  = 32'h4000_0000;
  localparam logic [WORD_W-1:0]  PROB_RST  = 32'h8000_0000;  // 0.5 in Q0.32
  localparam logic [WORD_W-1:0]  DISC_RST  = 32'h4000_0000;
  localparam logic [STEPS_W-1:0] STEPS_RST = 7'd1;

  // Configuration register map
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_UP_FACTOR   = 3'd0,
    REG_DOWN_FACTOR = 3'd1,
    REG_UP_PROB     = 3'd2,
    REG_DISCOUNT    = 3'd3,
    REG_NUM_STEPS   = 3'd4
  } cfg_reg_t;

  // Configuration bundle from the register block
  typedef struct packed {
    logic [WORD_W-1:0]  up_factor;
    logic [WORD_W-1:0]  down_factor;
    logic [WORD_W-1:0]  up_prob;
    logic [WORD_W-1:0]  discount;
    logic [STEPS_W-1:0] num_steps;
  } cfg_t;

  // Multiplier scaling: Q2.30 factor (shift 30, saturate) or Q0.32 weight (shift 32)
  typedef enum logic {
    MUL_Q30 = 1'b0,
    MUL_Q32 = 1'b1
  } mul_op_t;

  // Request into the shared multiplier; a is 33 bits to carry 1-p = 1.0
  typedef struct packed {
    mul_op_t           op;
    logic [WORD_W:0]   a;
    logic [WORD_W-1:0] b;
  } mul_req_t;

endpackage

// ===== hw/rtl/crr_cfg_regs.sv =====
// crr_cfg_regs: configuration register block (lattice factors and step count).
// Depends on crr_pkg.
`timescale 1ns / 1ps

module crr_cfg_regs import crr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [WORD_W-1:0]    wr_data,
  output cfg_t                 cfg
);

  cfg_t cfg_r;

  // Register write decode; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.up_factor   <= UP_RST;
      cfg_r.down_factor <= DOWN_RST;
      cfg_r.up_prob     <= PROB_RST;
      cfg_r.discount    <= DISC_RST;
      cfg_r.num_steps   <= STEPS_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_UP_FACTOR:   cfg_r.up_factor   <= wr_data;
        REG_DOWN_FACTOR: cfg_r.down_factor <= wr_data;
        REG_UP_PROB:     cfg_r.up_prob     <= wr_data;
        REG_DISCOUNT:    cfg_r.discount    <= wr_data;
        REG_NUM_STEPS:   cfg_r.num_steps   <= wr_data[STEPS_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== hw/rtl/crr_mul_unit.sv =====
// crr_mul_unit: the single shared fixed-point multiplier with scaling and
// saturation. Combinational; the caller registers the result. Depends on crr_pkg.
`timescale 1ns / 1ps

module crr_mul_unit import crr_pkg::*; (
  input  mul_req_t          req,
  output logic [WORD_W-1:0] res,
  output logic              sat
);

  logic [2*WORD_W:0] prod;

  assign prod = (2*WORD_W+1)'(req.a) * (2*WORD_W+1)'(req.b);

  // Scale back to Q16.16
  always_comb begin
    case (req.op)
      MUL_Q30: begin
        sat = |prod[2*WORD_W:2*WORD_W-2];
        res = sat ? '1 : prod[2*WORD_W-3:WORD_W-2];
      end
      MUL_Q32: begin
        // a <= 2^32 so the top product bit stays clear
        sat = 1'b0;
        res = prod[2*WORD_W-1:WORD_W];
      end
      default: begin
        sat = 1'b0;
        res = '0;
      end
    endcase
  end

endmodule

// ===== hw/rtl/crr_value_ram.sv =====
// crr_value_ram: node value memory, one write and one registered read port.
// No dependencies beyond its parameters.
`timescale 1ns / 1ps

module crr_value_ram #(
  parameter int DEPTH = 65,
  parameter int AW    = 7,
  parameter int DW    = 32
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/binomial_euro_call_pricer_core.sv =====
// Top level of the CRR binomial European call pricer: sequencer, datapath
// registers and node memory. Depends on crr_pkg, crr_cfg_regs, crr_mul_unit,
// crr_value_ram.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+------------------------------------------
//   input    | start / busy          | in_spot_price, in_strike_price
//   result   | out_valid (1 cycle)   | out_option_value, out_overflow
//   config   | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// Every product goes through the one shared multiplier, one per cycle, and
// each fold node needs three of them.
// busy is high from the cycle after start is taken until the result strobe.
// Reset is synchronous, active low; the node memory is not cleared, every entry
// is written before it is read. The result strobe cannot be stalled.
// cfg_ready is always high.
`timescale 1ns / 1ps

module binomial_euro_call_pricer_core import crr_pkg::*; #(
  parameter int MAX_STEPS = MAX_STEPS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [WORD_W-1:0]    in_spot_price,
  input  logic [WORD_W-1:0]    in_strike_price,
  output logic                 out_valid,
  output logic [WORD_W-1:0]    out_option_value,
  output logic                 out_overflow,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_data
);

  localparam int DEPTH = MAX_STEPS + 1;
  localparam int IW    = $clog2(MAX_STEPS + 1);

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_LEAF = 9'b000000010,
    ST_RDH  = 9'b000000100,
    ST_LDH  = 9'b000001000,
    ST_MA   = 9'b000010000,
    ST_MB   = 9'b000100000,
    ST_MD   = 9'b001000000,
    ST_RDF  = 9'b010000000,
    ST_OUT  = 9'b100000000
  } state_t;

  cfg_t              cfg;
  mul_req_t          mreq;
  logic [WORD_W-1:0] mres;
  logic              msat;

  state_t            state_r, state_nxt;
  logic [IW-1:0]     n_r, n_nxt;
  logic [IW-1:0]     j_r, j_nxt;
  logic [IW-1:0]     lvl_r, lvl_nxt;
  logic [IW-1:0]     up_left_r, up_left_nxt;
  logic [IW-1:0]     dn_left_r, dn_left_nxt;
  logic [WORD_W-1:0] spot_r, spot_nxt;
  logic [WORD_W-1:0] strike_r, strike_nxt;
  logic [WORD_W-1:0] acc_r, acc_nxt;
  logic [WORD_W-1:0] hi_r, hi_nxt;
  logic [WORD_W-1:0] lo_r, lo_nxt;
  logic [WORD_W-1:0] ta_r, ta_nxt;
  logic [WORD_W-1:0] sum_r, sum_nxt;
  logic              flag_r, flag_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0] out_value_r, out_value_nxt;
  logic              out_ovf_r, out_ovf_nxt;

  logic              mem_we;
  logic [IW-1:0]     mem_waddr, mem_raddr;
  logic [WORD_W-1:0] mem_wdata, mem_rdata;

  logic [31:0]       n_wide;
  logic [IW-1:0]     n_start;
  logic [WORD_W:0]   q_weight;
  logic [WORD_W:0]   fold_sum;

  assign cfg_ready = 1'b1;

  crr_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  crr_mul_unit u_mul (
    .req (mreq),
    .res (mres),
    .sat (msat)
  );

  crr_value_ram #(
    .DEPTH (DEPTH),
    .AW    (IW),
    .DW    (WORD_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Step count clamped to the lattice limit
  assign n_wide  = (32'(cfg.num_steps) > 32'(MAX_STEPS)) ? 32'(MAX_STEPS)
                                                         : 32'(cfg.num_steps);
  assign n_start = n_wide[IW-1:0];

  // Down weight 1-p as a 33-bit value (1.0 when p is zero)
  assign q_weight = {1'b1, {WORD_W{1'b0}}} - {1'b0, cfg.up_prob};
  assign fold_sum = {1'b0, ta_r} + {1'b0, mres};

  // Sequencer and multiplier operand select
  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    j_nxt         = j_r;
    lvl_nxt       = lvl_r;
    up_left_nxt   = up_left_r;
    dn_left_nxt   = dn_left_r;
    spot_nxt      = spot_r;
    strike_nxt    = strike_r;
    acc_nxt       = acc_r;
    hi_nxt        = hi_r;
    lo_nxt        = lo_r;
    ta_nxt        = ta_r;
    sum_nxt       = sum_r;
    flag_nxt      = flag_r;
    out_valid_nxt = 1'b0;
    out_value_nxt = out_value_r;
    out_ovf_nxt   = out_ovf_r;
    mreq.op       = MUL_Q30;
    mreq.a        = {1'b0, acc_r};
    mreq.b        = cfg.up_factor;
    mem_we        = 1'b0;
    mem_waddr     = j_r;
    mem_wdata     = (acc_r > strike_r) ? (acc_r - strike_r) : '0;
    mem_raddr     = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          n_nxt       = n_start;
          spot_nxt    = in_spot_price;
          strike_nxt  = in_strike_price;
          acc_nxt     = in_spot_price;
          j_nxt       = '0;
          up_left_nxt = n_start;
          dn_left_nxt = '0;
          flag_nxt    = 1'b0;
          state_nxt   = ST_LEAF;
        end
      end

      // Leaf price by repeated up then down multiplies, then payoff write
      ST_LEAF: begin
        if (up_left_r != '0) begin
          acc_nxt     = mres;
          flag_nxt    = flag_r | msat;
          up_left_nxt = up_left_r - 1'b1;
        end else if (dn_left_r != '0) begin
          mreq.b      = cfg.down_factor;
          acc_nxt     = mres;
          flag_nxt    = flag_r | msat;
          dn_left_nxt = dn_left_r - 1'b1;
        end else begin
          mem_we = 1'b1;
          if (j_r == n_r) begin
            lvl_nxt   = n_r;
            j_nxt     = '0;
            state_nxt = (n_r == '0) ? ST_RDF : ST_RDH;
          end else begin
            j_nxt       = IW'(j_r + 1'b1);
            acc_nxt     = spot_r;
            up_left_nxt = IW'(n_r - j_r - 1'b1);
            dn_left_nxt = IW'(j_r + 1'b1);
          end
        end
      end

      // Start of a level: fetch node 0, then node 1
      ST_RDH: begin
        mem_raddr = '0;
        state_nxt = ST_LDH;
      end

      ST_LDH: begin
        hi_nxt    = mem_rdata;
        mem_raddr = IW'(1);
        state_nxt = ST_MA;
      end

      // p * upper child
      ST_MA: begin
        lo_nxt    = mem_rdata;
        mreq.op   = MUL_Q32;
        mreq.a    = {1'b0, cfg.up_prob};
        mreq.b    = hi_r;
        ta_nxt    = mres;
        state_nxt = ST_MB;
      end

      // (1-p) * lower child, add, saturate
      ST_MB: begin
        mreq.op   = MUL_Q32;
        mreq.a    = q_weight;
        mreq.b    = lo_r;
        if (fold_sum[WORD_W]) begin
          sum_nxt  = '1;
          flag_nxt = 1'b1;
        end else begin
          sum_nxt  = fold_sum[WORD_W-1:0];
        end
        state_nxt = ST_MD;
      end

      // Discount and write back; prefetch next lower child
      ST_MD: begin
        mreq.a    = {1'b0, sum_r};
        mreq.b    = cfg.discount;
        flag_nxt  = flag_r | msat;
        mem_we    = 1'b1;
        mem_wdata = mres;
        hi_nxt    = lo_r;
        if (IW'(j_r + 1'b1) != lvl_r) begin
          j_nxt     = IW'(j_r + 1'b1);
          mem_raddr = IW'(j_r + 2'd2);
          state_nxt = ST_MA;
        end else if (lvl_r == IW'(1)) begin
          state_nxt = ST_RDF;
        end else begin
          lvl_nxt   = lvl_r - 1'b1;
          j_nxt     = '0;
          state_nxt = ST_RDH;
        end
      end

      // Root readout
      ST_RDF: begin
        mem_raddr = '0;
        state_nxt = ST_OUT;
      end

      ST_OUT: begin
        out_valid_nxt = 1'b1;
        out_value_nxt = mem_rdata;
        out_ovf_nxt   = flag_r;
        state_nxt     = ST_IDLE;
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      n_r         <= '0;
      j_r         <= '0;
      lvl_r       <= '0;
      up_left_r   <= '0;
      dn_left_r   <= '0;
      flag_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      n_r         <= n_nxt;
      j_r         <= j_nxt;
      lvl_r       <= lvl_nxt;
      up_left_r   <= up_left_nxt;
      dn_left_r   <= dn_left_nxt;
      flag_r      <= flag_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    spot_r      <= spot_nxt;
    strike_r    <= strike_nxt;
    acc_r       <= acc_nxt;
    hi_r        <= hi_nxt;
    lo_r        <= lo_nxt;
    ta_r        <= ta_nxt;
    sum_r       <= sum_nxt;
    out_value_r <= out_value_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  assign busy             = (state_r != ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_option_value = out_value_r;
  assign out_overflow     = out_ovf_r;

  // Checks
  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("sequencer state not one-hot");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted transfer did not raise busy");

  a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(state_r) == ST_OUT) && !busy)
    else $error("result strobe outside readout");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

endmodule
